// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the subdivider rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pss_pkg.sv -----
package pss_pkg;

    localparam int COORD_W_DEF    = 24;
    localparam int MAX_INSERT_DEF = 63;
    localparam int LEN_W          = 23;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_COUNT,
        ST_EMIT_CALC,
        ST_EMIT_OUT,
        ST_LAST_OUT
    } pss_state_t;

endpackage

// ----- hw/rtl/pss_serial_mul.sv -----
// shift-add unsigned multiplier, one multiplier bit per cycle
module pss_serial_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [AW-1:0]        a,
    input  logic [BW-1:0]        b,
    output logic                 done,
    output logic [AW+BW-1:0]     p
);
    import pss_pkg::*;

    localparam int CW = $clog2(BW + 1);

    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [AW+BW-1:0] mc_reg, mc_next;
    logic [BW-1:0]    mp_reg, mp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    // one partial product per cycle
    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = '0;
            mc_next   = (AW+BW)'(a);
            mp_next   = b;
            cnt_next  = CW'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0])
                acc_next = acc_reg + mc_reg;
            mc_next  = mc_reg << 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done = busy_reg && (cnt_reg == CW'(1)) && !start;
    assign p    = acc_next;
endmodule

// ----- hw/rtl/pss_serial_div.sv -----
// restoring divider for signed dividend by positive divisor, floor result
module pss_serial_div #(
    parameter int NW = 32,
    parameter int DW = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [NW-1:0]  num,
    input  logic [DW-1:0]         den,
    output logic                  done,
    output logic signed [NW-1:0]  quo
);
    import pss_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          fin_reg, fin_next;
    logic [DW:0]   trial;
    logic [NW-1:0] mag;
    logic [NW-1:0] qfix;

    assign mag = num[NW-1] ? (~num + NW'(1)) : num;

    // one quotient bit per cycle
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        trial     = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start)
        begin
            q_next    = mag;
            r_next    = '0;
            d_next    = den;
            neg_next  = num[NW-1];
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = q_reg << 1;
            r_next = trial;
            if (trial >= {1'b0, d_reg})
            begin
                r_next    = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // floor correction for negative dividend with nonzero remainder
    always_comb
    begin
        if (!neg_reg)
            qfix = q_reg;
        else if (r_reg != '0)
            qfix = ~q_reg;
        else
            qfix = ~q_reg + NW'(1);
    end

    assign done = fin_reg;
    assign quo  = $signed(qfix);
endmodule

// ----- hw/rtl/polyline_segment_subdivider.sv -----
// channel | dir | fields (low bit first)
// s_axis  | in  | tdata: x_in, y_in, z_in ; tuser: line_start
// m_axis  | out | tdata: x_out, y_out, z_out ; tlast: run_last ; tuser: count_clamped
// cfg     | in  | cfg_wdata: max_segment_length
// steps: accept when idle; a first vertex goes out alone in the next cycle; otherwise 3 squares
// and one count candidate per n from 1 (up to MAX_INSERT+1), each a shift-add multiply;
// each inserted point then adds three serial divides and one beat.
// reset clears the previous-vertex flag and loads the length register with 256.
// input is taken only when idle; an output beat waits in place until taken.
module polyline_segment_subdivider #(
    parameter int COORD_WIDTH = pss_pkg::COORD_W_DEF,
    parameter int MAX_INSERT  = pss_pkg::MAX_INSERT_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic                                cfg_we,
    input  logic [pss_pkg::LEN_W-1:0]           cfg_wdata,   // max_segment_length
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata, // x_in, y_in, z_in
    input  logic                                s_axis_tuser, // line_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_axis_tdata, // x_out, y_out, z_out
    output logic                                m_axis_tlast, // run_last
    output logic                                m_axis_tuser  // count_clamped
);
    import pss_pkg::*;
`include "assert_macros.svh"

    localparam int W    = COORD_WIDTH;
    localparam int DWD  = W + 1;          // difference width
    localparam int SQW  = 2*DWD + 2;      // sum of squares width
    localparam int NW   = $clog2(MAX_INSERT + 2);
    localparam int TW   = NW + LEN_W + 1; // candidate t = n*max
    localparam int MW   = (TW > DWD) ? TW : DWD;
    localparam int PW   = 2*MW;
    localparam int QW   = DWD + NW + 1;   // k*d width
    localparam int CMPW = (PW > SQW) ? PW : SQW;

    pss_state_t state_reg, state_next;

    logic [LEN_W-1:0]    len_reg;
    logic signed [W-1:0] px_reg, py_reg, pz_reg;
    logic signed [W-1:0] vx_reg, vy_reg, vz_reg, vx_next, vy_next, vz_next;
    logic                have_reg, have_next;
    logic signed [DWD-1:0] dx_reg, dy_reg, dz_reg, dx_next, dy_next, dz_next;
    logic [SQW-1:0]      m2_reg, m2_next;
    logic [1:0]          ax_reg, ax_next;
    logic [NW-1:0]       n_reg, n_next, k_reg, k_next;
    logic                clamp_reg, clamp_next;
    logic                wait_reg, wait_next;
    logic signed [W-1:0] ox_reg, oy_reg, oz_reg, ox_next, oy_next, oz_next;
    logic [LEN_W-1:0]    mx;
    logic                t2_over;

    // shared multiplier
    logic                mul_start;
    logic [MW-1:0]       mul_a;
    logic                mul_done;
    logic [PW-1:0]       mul_p;
    // divider
    logic                div_start, div_done;
    logic signed [QW-1:0] div_num, div_q;
    logic signed [QW-1:0] kd;
    logic signed [DWD-1:0] dsel, asel;
    logic [DWD-1:0]      absd;
    logic signed [W-1:0] psel;
    logic signed [W-1:0] pnew;

    assign mx = (len_reg == '0) ? LEN_W'(1) : len_reg;

    pss_serial_mul #(.AW(MW), .BW(MW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a(mul_a), .b(mul_a), .done(mul_done), .p(mul_p)
    );

    pss_serial_div #(.NW(QW), .DW(NW + 1)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(div_num), .den((NW+1)'(n_reg) + (NW+1)'(1)),
        .done(div_done), .quo(div_q)
    );

    // axis selection for squares and interpolation
    always_comb
    begin
        case (ax_reg)
            2'd0:    begin dsel = dx_reg; psel = px_reg; end
            2'd1:    begin dsel = dy_reg; psel = py_reg; end
            default: begin dsel = dz_reg; psel = pz_reg; end
        endcase
    end
    assign asel = dsel;
    assign absd = asel[DWD-1] ? (~asel + DWD'(1)) : asel;
    assign kd   = $signed({1'b0, k_reg}) * QW'(dsel);
    assign div_num = kd;
    assign pnew = W'(psel + W'(div_q));

    // candidate too long; at n = 1 a tie also stops, a segment exactly max long stays whole
    assign t2_over = (CMPW'(mul_p) > CMPW'(m2_reg)) ||
                     ((n_reg == NW'(1)) && (CMPW'(mul_p) == CMPW'(m2_reg)));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        vx_next = vx_reg; vy_next = vy_reg; vz_next = vz_reg;
        dx_next = dx_reg; dy_next = dy_reg; dz_next = dz_reg;
        have_next = have_reg;
        m2_next = m2_reg; ax_next = ax_reg;
        n_next = n_reg; k_next = k_reg;
        clamp_next = clamp_reg; wait_next = 1'b0;
        ox_next = ox_reg; oy_next = oy_reg; oz_next = oz_reg;
        mul_start = 1'b0; mul_a = '0; div_start = 1'b0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    vx_next = s_axis_tdata[W-1:0];
                    vy_next = s_axis_tdata[2*W-1:W];
                    vz_next = s_axis_tdata[3*W-1:2*W];
                    dx_next = DWD'($signed(s_axis_tdata[W-1:0])) - DWD'(px_reg);
                    dy_next = DWD'($signed(s_axis_tdata[2*W-1:W])) - DWD'(py_reg);
                    dz_next = DWD'($signed(s_axis_tdata[3*W-1:2*W])) - DWD'(pz_reg);
                    clamp_next = 1'b0;
                    n_next = '0;
                    k_next = NW'(1);
                    m2_next = '0;
                    ax_next = 2'd0;
                    wait_next = 1'b1;
                    if (have_reg && !s_axis_tuser)
                        state_next = ST_SQUARE;
                    else
                        state_next = ST_LAST_OUT;
                end
            end
            ST_SQUARE:
            begin
                mul_a = MW'(absd);
                if (wait_reg)
                    mul_start = 1'b1;
                else if (mul_done)
                begin
                    m2_next = m2_reg + SQW'(mul_p);
                    if (ax_reg == 2'd2)
                    begin
                        ax_next = 2'd0;
                        n_next = NW'(1);
                        wait_next = 1'b1;
                        state_next = ST_COUNT;
                    end
                    else
                    begin
                        ax_next = ax_reg + 2'd1;
                        wait_next = 1'b1;
                    end
                end
            end
            ST_COUNT:
            begin
                // candidate t = n*max; n counts up from 1
                mul_a = MW'(TW'(n_reg) * TW'(mx));
                if (wait_reg)
                    mul_start = 1'b1;
                else if (mul_done)
                begin
                    if (t2_over)
                    begin
                        // n-1 fits
                        n_next = n_reg - NW'(1);
                        if (n_reg == NW'(1))
                            state_next = ST_LAST_OUT;
                        else
                        begin
                            k_next = NW'(1);
                            ax_next = 2'd0;
                            wait_next = 1'b1;
                            state_next = ST_EMIT_CALC;
                        end
                    end
                    else if (n_reg == NW'(MAX_INSERT + 1))
                    begin
                        clamp_next = 1'b1;
                        n_next = NW'(MAX_INSERT);
                        k_next = NW'(1);
                        ax_next = 2'd0;
                        wait_next = 1'b1;
                        state_next = ST_EMIT_CALC;
                    end
                    else
                    begin
                        n_next = n_reg + NW'(1);
                        wait_next = 1'b1;
                    end
                end
            end
            ST_EMIT_CALC:
            begin
                if (wait_reg)
                    div_start = 1'b1;
                else if (div_done)
                begin
                    case (ax_reg)
                        2'd0:    ox_next = pnew;
                        2'd1:    oy_next = pnew;
                        default: oz_next = pnew;
                    endcase
                    if (ax_reg == 2'd2)
                    begin
                        ax_next = 2'd0;
                        state_next = ST_EMIT_OUT;
                    end
                    else
                    begin
                        ax_next = ax_reg + 2'd1;
                        wait_next = 1'b1;
                    end
                end
            end
            ST_EMIT_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    if (k_reg == n_reg)
                        state_next = ST_LAST_OUT;
                    else
                    begin
                        k_next = k_reg + NW'(1);
                        wait_next = 1'b1;
                        state_next = ST_EMIT_CALC;
                    end
                end
            end
            ST_LAST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    have_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            have_reg  <= 1'b0;
            len_reg   <= LEN_RESET;
            px_reg    <= '0;
            py_reg    <= '0;
            pz_reg    <= '0;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            have_reg  <= have_next;
            wait_reg  <= wait_next;
            if (cfg_we)
                len_reg <= cfg_wdata;
            if (state_reg == ST_LAST_OUT && m_axis_tready)
            begin
                px_reg <= vx_reg;
                py_reg <= vy_reg;
                pz_reg <= vz_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg <= vx_next; vy_reg <= vy_next; vz_reg <= vz_next;
        dx_reg <= dx_next; dy_reg <= dy_next; dz_reg <= dz_next;
        m2_reg <= m2_next; ax_reg <= ax_next;
        n_reg <= n_next; k_reg <= k_next;
        clamp_reg <= clamp_next;
        ox_reg <= ox_next; oy_reg <= oy_next; oz_reg <= oz_next;
    end

    // output beat
    always_comb
    begin
        m_axis_tdata = '0;
        if (state_reg == ST_LAST_OUT)
            m_axis_tdata[3*W-1:0] = {vz_reg, vy_reg, vx_reg};
        else
            m_axis_tdata[3*W-1:0] = {oz_reg, oy_reg, ox_reg};
    end
    assign m_axis_tlast = (state_reg == ST_LAST_OUT);
    assign m_axis_tuser = clamp_reg;

    `ASSERT_IMPL(a_no_in_busy, clk, rst_n, state_reg != ST_IDLE, !s_axis_tready,
        "input taken while busy")
    `ASSERT_NEXT(a_last_idle, clk, rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast,
        state_reg == ST_IDLE, "no return to idle after run end")
    `ASSERT_IMPL(a_k_range, clk, rst_n, state_reg == ST_EMIT_OUT,
        k_reg <= n_reg && k_reg != '0, "insert index out of range")
endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    import pss_pkg::*;

    localparam int CW = 24;
    localparam int NMAX = 63;
    localparam int DW = ((3*CW+7)/8)*8;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          last;
        logic          clamp;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tuser;

    // model state
    logic [LEN_W-1:0] seg_len;
    longint last_x, last_y, last_z;
    bit have_last;

    point_t expected_points[$];
    int errors = 0;
    int points_seen = 0;
    int vertices_sent = 0;
    int clamp_runs = 0;
    bit hold_off = 1'b0;
    bit stall_on = 1'b1;

    polyline_segment_subdivider dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    always #1 clk = ~clk;

    // run limit
    initial
    begin
        #20000000;
        $display("timeout at %0t", $time);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic longint sq_capped(longint d);
        longint a;
        a = (d < 0) ? -d : d;
        if (a >= (64'sd1 <<< 30))
            return 64'sd1 <<< 62;
        return a * a;
    endfunction

    function automatic longint div_floor(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q--;
        return q;
    endfunction

    function automatic point_t mk_point(longint x, longint y, longint z, bit l, bit c);
        point_t p;
        p.x = x[CW-1:0];
        p.y = y[CW-1:0];
        p.z = z[CW-1:0];
        p.last = l;
        p.clamp = c;
        return p;
    endfunction

    // append one predicted point
    function automatic void add_expected(point_t p);
        expected_points.insert(expected_points.size(), p);
    endfunction

    // predict the points one vertex yields
    task automatic subdivide_vertex(logic [CW-1:0] xi, logic [CW-1:0] yi,
                                    logic [CW-1:0] zi, bit start);
        longint x, y, z, dx, dy, dz, len2, cap, mx, n, t;
        bit clamp;
        x = longint'(signed'(xi));
        y = longint'(signed'(yi));
        z = longint'(signed'(zi));
        cap = 64'sd1 <<< 62;
        clamp = 1'b0;
        if (have_last && !start)
        begin
            dx = x - last_x;
            dy = y - last_y;
            dz = z - last_z;
            mx = (seg_len == 0) ? 1 : longint'(seg_len);
            len2 = sq_capped(dx) + sq_capped(dy);
            if (len2 > cap) len2 = cap;
            len2 += sq_capped(dz);
            if (len2 > cap) len2 = cap;
            if (len2 > mx * mx)
            begin
                n = 1;
                while (n < NMAX)
                begin
                    t = (n + 1) * mx;
                    if (t * t > len2)
                        break;
                    n++;
                end
                t = (NMAX + 1) * mx;
                if (t * t <= len2)
                    clamp = 1'b1;
                if (clamp)
                    clamp_runs++;
                for (longint k = 1; k <= n; k++)
                    add_expected(mk_point(
                        last_x + div_floor(k * dx, n + 1),
                        last_y + div_floor(k * dy, n + 1),
                        last_z + div_floor(k * dz, n + 1), 1'b0, clamp));
            end
            add_expected(mk_point(x, y, z, 1'b1, clamp));
        end
        else
            add_expected(mk_point(x, y, z, 1'b1, 1'b0));
        last_x = x;
        last_y = y;
        last_z = z;
        have_last = 1'b1;
    endtask

    // send one vertex beat, then predict
    task automatic send_vertex(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                               bit start);
        s_axis_tdata <= DW'({z, y, x});
        s_axis_tuser <= start;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        s_axis_tvalid <= 1'b0;
        subdivide_vertex(x, y, z, start);
        vertices_sent++;
        @(posedge clk);
    endtask

    // random gap between bursts
    int burst_left = 0;
    task automatic maybe_gap();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            repeat ($urandom_range(0, 12)) @(posedge clk);
        end
        burst_left--;
    endtask

    task automatic drain();
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (20000) @(posedge clk);
    endtask

    task automatic write_len(logic [LEN_W-1:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        seg_len = v;
    endtask

    function automatic logic [CW-1:0] rand_coord();
        return CW'($urandom);
    endfunction

    // result receiver stall pattern
    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if (stall_on)
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        else
            m_axis_tready <= 1'b1;
    end

    // compare each result beat
    always @(posedge clk)
    begin
        point_t exp_p, got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[CW-1:0], m_axis_tdata[2*CW-1:CW],
                   m_axis_tdata[3*CW-1:2*CW], m_axis_tlast, m_axis_tuser};
            points_seen++;
            if (expected_points.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat actual %h", $time, got);
            end
            else
            begin
                exp_p = expected_points.pop_front();
                if (got.x !== exp_p.x || got.y !== exp_p.y || got.z !== exp_p.z
                    || got.last !== exp_p.last || got.clamp !== exp_p.clamp)
                begin
                    errors++;
                    $display("%0t: mismatch expected x=%h y=%h z=%h last=%b clamp=%b",
                             $time, exp_p.x, exp_p.y, exp_p.z, exp_p.last, exp_p.clamp);
                    $display("%0t:          actual   x=%h y=%h z=%h last=%b clamp=%b",
                             $time, got.x, got.y, got.z, got.last, got.clamp);
                end
            end
        end
    end

    // corners at reset length
    task automatic test_directed();
        send_vertex(24'h000000, 24'h000000, 24'h000000, 1'b1);
        send_vertex(24'h000100, 24'h000000, 24'h000000, 1'b0);
        send_vertex(24'h000201, 24'h000000, 24'h000000, 1'b0);
        send_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_vertex(24'h800000, 24'h800000, 24'h800000, 1'b0);
        send_vertex(24'h800000, 24'h7FFFFF, 24'h000000, 1'b1);
        send_vertex(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 1'b0);
        send_vertex(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_vertex(24'hFFFD00, 24'h000300, 24'hFFFFFF, 1'b0);
        send_vertex(24'hFFFD00, 24'h000300, 24'hFFFFFF, 1'b0);
        send_vertex(24'h000005, 24'hFFFFF9, 24'h000003, 1'b1);
    endtask

    // smallest register, zero acting as one
    task automatic test_min_length();
        write_len(23'd0);
        send_vertex(24'h000000, 24'h000000, 24'h000000, 1'b1);
        send_vertex(24'h000001, 24'h000000, 24'h000000, 1'b0);
        send_vertex(24'h000003, 24'hFFFFFF, 24'h000000, 1'b0);
        send_vertex(24'h000100, 24'h000000, 24'h000000, 1'b0);
        write_len(23'd1);
        send_vertex(24'hFFFFF0, 24'h000007, 24'hFFFFFB, 1'b0);
        send_vertex(24'h000010, 24'h000000, 24'h000000, 1'b0);
    endtask

    // largest register
    task automatic test_max_length();
        write_len(23'h7FFFFF);
        send_vertex(24'h800000, 24'h800000, 24'h800000, 1'b1);
        send_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_vertex(24'h000000, 24'h000000, 24'h000000, 1'b0);
    endtask

    // random polylines, long receiver hold-off included
    task automatic test_random(int count, int lo, int hi);
        logic [CW-1:0] bx, by, bz;
        int span;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                write_len(LEN_W'($urandom_range(lo, hi)));
            if (i == count / 2)
                hold_off = 1'b1;
            stall_on = ((i / 30) % 2 == 0);
            maybe_gap();
            span = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0)
            begin
                bx = rand_coord();
                by = rand_coord();
                bz = rand_coord();
            end
            else
            begin
                // mostly steps a few segment lengths long
                bx = CW'(last_x + $signed($urandom_range(0, seg_len * 4 + 8)) -
                         (seg_len * 2 + 4) * (span + 1) / 2);
                by = CW'(last_y + $signed($urandom_range(0, seg_len * 4 + 8)) -
                         (seg_len * 2 + 4) / 2);
                bz = CW'(last_z + $signed($urandom_range(0, seg_len * 2 + 4)) -
                         (seg_len + 2) / 2);
            end
            send_vertex(bx, by, bz, $urandom_range(0, 15) == 0);
        end
    endtask

    // hold the receiver off while vertices are still offered
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            wait (hold_off);
            repeat (3000) @(posedge clk);
            hold_off = 1'b0;
        end
    end

    initial
    begin
        seg_len = LEN_RESET;
        last_x = 0;
        last_y = 0;
        last_z = 0;
        have_last = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_min_length();
        test_max_length();
        write_len(23'd256);
        // pause until all points are back
        drain();
        test_random(120, 64, 4096);
        test_random(80, 1, 40);
        drain();
        $display("sent %0d vertices, checked %0d points, %0d clamped runs",
                 vertices_sent, points_seen, clamp_runs);
        $display("lengths covered 0, 1, max, reset and random ranges");
        if (errors == 0 && expected_points.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
